FILE: src/jdh_pkg.sv
// Shared constants, register indexes, heading codes and interface structs
// for the joystick direction decoder. No dependencies.
package jdh_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int CENTER_BITS     = 10;
    localparam int LEVEL_BITS      = 7;
    localparam int CFG_DATA_BITS   = 10;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int PCT_BITS        = 7;
    localparam int PCT_OUT_BITS    = 8;
    localparam int HD_BITS         = 3;
    localparam int PCT_SCALE       = 100;

    localparam logic [CFG_INDEX_BITS-1:0] REG_X_CENTER    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_CENTER    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEAD_ZONE   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENTER_LEVEL = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEAVE_LEVEL = 3'd4;

    localparam logic [CENTER_BITS-1:0] CENTER_RESET = 10'd512;
    localparam logic [LEVEL_BITS-1:0]  DEAD_RESET   = 7'd10;
    localparam logic [LEVEL_BITS-1:0]  ENTER_RESET  = 7'd50;
    localparam logic [LEVEL_BITS-1:0]  LEAVE_RESET  = 7'd30;

    localparam logic [HD_BITS-1:0] HD_CENTER = 3'd0;
    localparam logic [HD_BITS-1:0] HD_UP     = 3'd1;
    localparam logic [HD_BITS-1:0] HD_DOWN   = 3'd2;
    localparam logic [HD_BITS-1:0] HD_LEFT   = 3'd3;
    localparam logic [HD_BITS-1:0] HD_RIGHT  = 3'd4;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [PCT_BITS-1:0] quot;
    } div_stat_t;

    typedef struct packed {
        logic [HD_BITS-1:0] heading;
        logic [HD_BITS-1:0] moved;
    } hd_res_t;

endpackage

FILE: src/jdh_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, PCT_BITS bits in all.
// Depends on jdh_pkg.
module jdh_div #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [SAMPLE_BITS+6:0]     numer,
    input  logic [SAMPLE_BITS-1:0]     denom,
    output jdh_pkg::div_stat_t         stat
);
    import jdh_pkg::*;

    localparam int NW = SAMPLE_BITS + PCT_BITS;
    localparam int CW = $clog2(PCT_BITS);

    logic [NW-1:0]       rem_reg, rem_next;
    logic [NW-1:0]       dsh_reg, dsh_next;
    logic [PCT_BITS-1:0] quot_reg, quot_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                fits;

    assign fits = rem_reg >= dsh_reg;

    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = numer;
            dsh_next  = NW'(denom) << (PCT_BITS - 1);
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - dsh_reg;
            end
            quot_next = {quot_reg[PCT_BITS-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg + CW'(1);
            if (cnt_reg == CW'(PCT_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

endmodule

FILE: src/jdh_heading.sv
// Heading decision with hysteresis; holds the current heading.
// Depends on jdh_pkg.
module jdh_heading (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    update,
    input  logic signed [jdh_pkg::PCT_OUT_BITS-1:0] x_pct,
    input  logic signed [jdh_pkg::PCT_OUT_BITS-1:0] y_pct,
    input  logic [jdh_pkg::LEVEL_BITS-1:0]          enter_level,
    input  logic [jdh_pkg::LEVEL_BITS-1:0]          leave_level,
    output jdh_pkg::hd_res_t                        res
);
    import jdh_pkg::*;

    function automatic logic signed [PCT_OUT_BITS:0] push_toward(
        input logic [HD_BITS-1:0]             hd,
        input logic signed [PCT_OUT_BITS-1:0] xp,
        input logic signed [PCT_OUT_BITS-1:0] yp
    );
        logic signed [PCT_OUT_BITS:0] xw;
        logic signed [PCT_OUT_BITS:0] yw;
        logic signed [PCT_OUT_BITS:0] r;
        xw = {xp[PCT_OUT_BITS-1], xp};
        yw = {yp[PCT_OUT_BITS-1], yp};
        case (hd)
            HD_UP:    r = yw;
            HD_DOWN:  r = -yw;
            HD_LEFT:  r = -xw;
            HD_RIGHT: r = xw;
            default:  r = '0;
        endcase
        return r;
    endfunction

    logic [HD_BITS-1:0]           cur_reg, cur_next;
    logic [PCT_OUT_BITS-1:0]      xneg, yneg;
    logic [PCT_BITS-1:0]          ax, ay, bmag;
    logic [HD_BITS-1:0]           horiz, vert, best, pick;
    logic signed [PCT_OUT_BITS:0] push_cur;
    logic                         keep;

    assign xneg = -x_pct;
    assign yneg = -y_pct;
    assign ax   = x_pct[PCT_OUT_BITS-1] ? xneg[PCT_BITS-1:0] : x_pct[PCT_BITS-1:0];
    assign ay   = y_pct[PCT_OUT_BITS-1] ? yneg[PCT_BITS-1:0] : y_pct[PCT_BITS-1:0];

    assign horiz = (x_pct > 0) ? HD_RIGHT : HD_LEFT;
    assign vert  = (y_pct > 0) ? HD_UP : HD_DOWN;
    assign best  = (ax > ay) ? horiz : vert;
    assign bmag  = (ax > ay) ? ax : ay;
    assign pick  = (bmag > enter_level) ? best : HD_CENTER;

    assign push_cur = push_toward(cur_reg, x_pct, y_pct);
    assign keep     = push_cur >= $signed({2'b00, leave_level});
    assign cur_next = keep ? cur_reg : pick;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= HD_CENTER;
        end else if (update) begin
            cur_reg <= cur_next;
        end
    end

    assign res.heading = cur_next;
    assign res.moved   = (cur_next != cur_reg) ? cur_next : HD_CENTER;

endmodule

FILE: src/joystick_direction_hysteresis_top.sv
// Joystick direction decoder top: config registers, sequencer, output register.
// Depends on jdh_pkg, jdh_div, jdh_heading.
//
//  channel | dir | fields (tdata, low bit first)
//  s_      | in  | x_sample, y_sample
//  m_      | out | x_percent, y_percent, heading, moved_to
//  cfg_    | in  | write enable, register index, write data
//
// Per request: accept, then per axis a setup state, seven steps of the shared
// bit-serial divider and taking the quotient, then loading the result.
// Reset restores default config and center heading.
// A new request is taken only while the sequencer is idle; a finished result
// waits in the output register and blocks only the load of the next one.
module joystick_direction_hysteresis_top #(
    parameter int SAMPLE_BITS = jdh_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // x_sample, y_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // x_percent, y_percent, heading, moved_to
    output logic [23:0]                          m_tdata,
    input  logic                                 cfg_we,
    input  logic [jdh_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [jdh_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
    import jdh_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int NW = SAMPLE_BITS + PCT_BITS;
    localparam logic [SB-1:0] CENTER_INIT = {1'b1, {(SB-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [SB-1:0]          x_center_reg, y_center_reg;
    logic [LEVEL_BITS-1:0]  dead_zone_reg, enter_level_reg, leave_level_reg;

    logic [SB-1:0]                  x_s_reg, y_s_reg;
    logic                           axis_reg, axis_next;
    logic                           neg_reg, zero_reg;
    logic signed [PCT_OUT_BITS-1:0] x_pct_reg, y_pct_reg, pct_val;
    logic                           m_valid_reg, m_valid_next;
    logic [23:0]                    m_data_reg;

    logic [SB-1:0]   xc, yc, s_sel, c_sel, mag, span;
    logic            neg;
    logic [NW-1:0]   numer;
    div_stat_t       dstat;
    hd_res_t         hres;
    logic            div_start, load_out, out_free;
    logic [PCT_OUT_BITS-1:0] qneg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_center_reg    <= CENTER_INIT;
            y_center_reg    <= CENTER_INIT;
            dead_zone_reg   <= DEAD_RESET;
            enter_level_reg <= ENTER_RESET;
            leave_level_reg <= LEAVE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_X_CENTER:    x_center_reg    <= SB'(cfg_wdata[CENTER_BITS-1:0]);
                REG_Y_CENTER:    y_center_reg    <= SB'(cfg_wdata[CENTER_BITS-1:0]);
                REG_DEAD_ZONE:   dead_zone_reg   <= cfg_wdata[LEVEL_BITS-1:0];
                REG_ENTER_LEVEL: enter_level_reg <= cfg_wdata[LEVEL_BITS-1:0];
                REG_LEAVE_LEVEL: leave_level_reg <= cfg_wdata[LEVEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // axis setup: offset magnitude and span on the offset's side
    assign xc    = x_center_reg;
    assign yc    = y_center_reg;
    assign s_sel = axis_reg ? y_s_reg : x_s_reg;
    assign c_sel = axis_reg ? yc : xc;
    assign neg   = s_sel < c_sel;
    assign mag   = neg ? (c_sel - s_sel) : (s_sel - c_sel);
    assign span  = neg ? c_sel : ({SB{1'b1}} - c_sel);
    assign numer = NW'(mag) * NW'(PCT_SCALE);

    assign div_start = (state_reg == S_PREP);

    jdh_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (numer),
        .denom   (span),
        .stat    (dstat)
    );

    assign qneg = -{1'b0, dstat.quot};
    always_comb begin
        if (zero_reg || (dstat.quot < dead_zone_reg)) begin
            pct_val = '0;
        end else if (neg_reg) begin
            pct_val = $signed(qneg);
        end else begin
            pct_val = $signed({1'b0, dstat.quot});
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign load_out = (state_reg == S_DONE) && out_free;
    assign s_tready = (state_reg == S_IDLE);

    jdh_heading u_heading (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .update      (load_out),
        .x_pct       (x_pct_reg),
        .y_pct       (y_pct_reg),
        .enter_level (enter_level_reg),
        .leave_level (leave_level_reg),
        .res         (hres)
    );

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_PREP;
                    axis_next  = 1'b0;
                end
            end
            S_PREP: state_next = S_DIV;
            S_DIV: begin
                if (dstat.done) begin
                    if (axis_reg) begin
                        state_next = S_DONE;
                    end else begin
                        axis_next  = 1'b1;
                        state_next = S_PREP;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            axis_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            m_valid_reg <= m_valid_next;
        end
        if (s_tvalid && s_tready) begin
            x_s_reg <= s_tdata[SB-1:0];
            y_s_reg <= s_tdata[2*SB-1:SB];
        end
        if (div_start) begin
            neg_reg  <= neg;
            zero_reg <= (mag == '0);
        end
        if ((state_reg == S_DIV) && dstat.done) begin
            if (axis_reg) begin
                y_pct_reg <= pct_val;
            end else begin
                x_pct_reg <= pct_val;
            end
        end
        if (load_out) begin
            m_data_reg <= {2'b00, hres.moved, hres.heading, y_pct_reg, x_pct_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        dstat.done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide state");

    a_div_free_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !dstat.busy)
        else $error("divider started while busy");

    a_moved_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[21:19] != HD_CENTER)) |-> (m_tdata[21:19] == m_tdata[18:16]))
        else $error("moved_to differs from heading");

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18:16] <= HD_RIGHT))
        else $error("heading code out of range");
`endif

endmodule

FILE: verif/joystick_direction_hysteresis_top_test.sv
// Self-checking bench for joystick_direction_hysteresis_top: directed and random
// sample pairs, config sweeps, stalls on both streams. Depends on jdh_pkg and the RTL.
module joystick_direction_hysteresis_top_test;
    import jdh_pkg::*;

    localparam int SMP_BITS       = SAMPLE_BITS_DEF;
    localparam int FULL_SCALE     = (1 << SMP_BITS) - 1;
    localparam int S_DATA_W       = ((2*SMP_BITS+7)/8)*8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_ITEMS   = 190;

    typedef struct packed {
        logic [SMP_BITS-1:0] y;
        logic [SMP_BITS-1:0] x;
    } sample_pair_t;

    typedef struct {
        logic signed [PCT_OUT_BITS-1:0] x_pct;
        logic signed [PCT_OUT_BITS-1:0] y_pct;
        logic [HD_BITS-1:0]             heading;
        logic [HD_BITS-1:0]             moved;
    } report_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [S_DATA_W-1:0]        s_tdata   = '0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [23:0]                m_tdata;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_wdata = '0;

    // register mirror and heading tracked by the predictor
    logic [SMP_BITS-1:0]   x_center_cfg = CENTER_RESET;
    logic [SMP_BITS-1:0]   y_center_cfg = CENTER_RESET;
    logic [LEVEL_BITS-1:0] dead_cfg     = DEAD_RESET;
    logic [LEVEL_BITS-1:0] enter_cfg    = ENTER_RESET;
    logic [LEVEL_BITS-1:0] leave_cfg    = LEAVE_RESET;
    logic [HD_BITS-1:0]    heading_model = HD_CENTER;

    sample_pair_t pending_samples[$];
    report_t      predicted_reports[$];
    int           samples_sent = 0;
    int           reports_seen = 0;
    int           mismatches   = 0;
    int           tx_idle_pct  = 32;
    int           rx_idle_pct  = 51;
    bit           hold_pending = 1'b0;
    int           hold_left    = 0;
    int           idle_cycles  = 0;

    always #5 aclk = ~aclk;

    joystick_direction_hysteresis_top #(
        .SAMPLE_BITS(SMP_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    function automatic int axis_percent(logic [SMP_BITS-1:0] sample,
                                        logic [SMP_BITS-1:0] center);
        int s;
        int c;
        int off;
        int span;
        int pct;
        int dz;
        s   = sample;
        c   = center;
        dz  = dead_cfg;
        off = s - c;
        if (off == 0) begin
            return 0;
        end
        span = (off > 0) ? FULL_SCALE - c : c;
        pct  = off * PCT_SCALE / span;
        if (pct > -dz && pct < dz) begin
            return 0;
        end
        return pct;
    endfunction

    function automatic int push_along(logic [HD_BITS-1:0] hd, int xp, int yp);
        case (hd)
            HD_UP:    return yp;
            HD_DOWN:  return -yp;
            HD_LEFT:  return -xp;
            HD_RIGHT: return xp;
            default:  return 0;
        endcase
    endfunction

    function automatic report_t decode_direction(sample_pair_t smp);
        report_t            r;
        int                 xp;
        int                 yp;
        int                 enter_lvl;
        int                 leave_lvl;
        logic [HD_BITS-1:0] horiz;
        logic [HD_BITS-1:0] vert;
        logic [HD_BITS-1:0] best;
        logic [HD_BITS-1:0] next_hd;
        enter_lvl = enter_cfg;
        leave_lvl = leave_cfg;
        xp = axis_percent(smp.x, x_center_cfg);
        yp = axis_percent(smp.y, y_center_cfg);
        if (push_along(heading_model, xp, yp) >= leave_lvl) begin
            next_hd = heading_model;
        end else begin
            horiz = (xp > 0) ? HD_RIGHT : HD_LEFT;
            vert  = (yp > 0) ? HD_UP : HD_DOWN;
            best  = (push_along(horiz, xp, yp) > push_along(vert, xp, yp)) ? horiz : vert;
            next_hd = (push_along(best, xp, yp) > enter_lvl) ? best : HD_CENTER;
        end
        r.x_pct   = PCT_OUT_BITS'(xp);
        r.y_pct   = PCT_OUT_BITS'(yp);
        r.moved   = (next_hd != heading_model) ? next_hd : HD_CENTER;
        r.heading = next_hd;
        heading_model = next_hd;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // sample driver
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predicted_reports.push_back(decode_direction(s_tdata[2*SMP_BITS-1:0]));
        end
        if (!s_tvalid || s_tready) begin
            if (aresetn && pending_samples.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= S_DATA_W'(pending_samples.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // report monitor and receiver stalls
    always @(posedge aclk) begin : check_reports
        report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            reports_seen++;
            if (predicted_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, actual %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = predicted_reports.pop_front();
                check_field("x_percent", want.x_pct, $signed(m_tdata[7:0]));
                check_field("y_percent", want.y_pct, $signed(m_tdata[15:8]));
                check_field("heading", want.heading, m_tdata[18:16]);
                check_field("moved_to", want.moved, m_tdata[21:19]);
            end
        end
        if (hold_pending) begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
        end
        m_tready <= aresetn && hold_left == 0 && $urandom_range(0, 99) >= rx_idle_pct;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress on either stream", $time);
                $display("FAIL joystick_direction_hysteresis_top");
                $finish;
            end
        end
    end

    task automatic queue_pair(int x, int y);
        sample_pair_t p;
        p.x = SMP_BITS'(x);
        p.y = SMP_BITS'(y);
        pending_samples.push_back(p);
        samples_sent++;
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_X_CENTER:    x_center_cfg = val[SMP_BITS-1:0];
            REG_Y_CENTER:    y_center_cfg = val[SMP_BITS-1:0];
            REG_DEAD_ZONE:   dead_cfg     = val[LEVEL_BITS-1:0];
            REG_ENTER_LEVEL: enter_cfg    = val[LEVEL_BITS-1:0];
            REG_LEAVE_LEVEL: leave_cfg    = val[LEVEL_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle;
        do @(posedge aclk); while (reports_seen < samples_sent);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic int clamp_sample(int v);
        return (v < 0) ? 0 : (v > FULL_SCALE) ? FULL_SCALE : v;
    endfunction

    function automatic int axis_target(int c);
        int d;
        d = $urandom_range(0, 400);
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return FULL_SCALE;
            2:       return c;
            3:       return $urandom_range(0, FULL_SCALE);
            default: return clamp_sample(c + d - 200);
        endcase
    endfunction

    // runs of held stick positions with jitter, mixed with raw noise
    task automatic queue_gestures(int count);
        int made;
        int run;
        int noise;
        int tx;
        int ty;
        int jx;
        int jy;
        made = 0;
        while (made < count) begin
            run   = $urandom_range(1, 8);
            noise = ($urandom_range(0, 4) == 0);
            tx    = axis_target(x_center_cfg);
            ty    = axis_target(y_center_cfg);
            for (int i = 0; i < run && made < count; i++) begin
                jx = $urandom_range(0, 30);
                jy = $urandom_range(0, 30);
                if (noise) begin
                    queue_pair($urandom_range(0, FULL_SCALE), $urandom_range(0, FULL_SCALE));
                end else begin
                    queue_pair(clamp_sample(tx + jx - 15), clamp_sample(ty + jy - 15));
                end
                made++;
            end
        end
    endtask

    task automatic randomize_config(int c_lo, int c_hi, int dz_hi, int en_lo, int en_hi,
                                    int lv_hi);
        write_reg(REG_X_CENTER, CFG_DATA_BITS'($urandom_range(c_lo, c_hi)));
        write_reg(REG_Y_CENTER, CFG_DATA_BITS'($urandom_range(c_lo, c_hi)));
        write_reg(REG_DEAD_ZONE, {(CFG_DATA_BITS-LEVEL_BITS)'($urandom),
                                  LEVEL_BITS'($urandom_range(0, dz_hi))});
        write_reg(REG_ENTER_LEVEL, {(CFG_DATA_BITS-LEVEL_BITS)'($urandom),
                                    LEVEL_BITS'($urandom_range(en_lo, en_hi))});
        write_reg(REG_LEAVE_LEVEL, {(CFG_DATA_BITS-LEVEL_BITS)'($urandom),
                                    LEVEL_BITS'($urandom_range(0, lv_hi))});
        end_writes();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // default config: full throws, hold, dead zone and threshold edges, tie
        queue_pair(512, 512);
        queue_pair(FULL_SCALE, 512);
        queue_pair(FULL_SCALE, 512);
        queue_pair(0, 512);
        queue_pair(512, FULL_SCALE);
        queue_pair(512, 0);
        queue_pair(FULL_SCALE, FULL_SCALE);
        queue_pair(560, 512);
        queue_pair(564, 512);
        queue_pair(768, 512);
        queue_pair(773, 512);
        queue_pair(666, 512);
        queue_pair(665, 512);
        wait_idle();

        // centers at the ends, thresholds at and above 100, unused indexes
        write_reg(REG_X_CENTER, CFG_DATA_BITS'(FULL_SCALE));
        write_reg(REG_Y_CENTER, '0);
        write_reg(REG_DEAD_ZONE, '1);
        write_reg(REG_ENTER_LEVEL, '1);
        write_reg(REG_LEAVE_LEVEL, CFG_DATA_BITS'(PCT_SCALE));
        for (int i = REG_LEAVE_LEVEL + 1; i < (1 << CFG_INDEX_BITS); i++) begin
            write_reg(CFG_INDEX_BITS'(i), '1);
        end
        end_writes();
        queue_pair(0, 0);
        queue_pair(FULL_SCALE, FULL_SCALE);
        queue_pair(512, 300);
        wait_idle();

        // all levels zero: center is held
        write_reg(REG_X_CENTER, '0);
        write_reg(REG_Y_CENTER, CFG_DATA_BITS'(FULL_SCALE));
        write_reg(REG_DEAD_ZONE, '0);
        write_reg(REG_ENTER_LEVEL, '0);
        write_reg(REG_LEAVE_LEVEL, '0);
        end_writes();
        queue_pair(0, FULL_SCALE);
        queue_pair(FULL_SCALE, 0);
        queue_pair(1, FULL_SCALE - 1);
        wait_idle();

        randomize_config(300, 700, 20, 30, 70, 50);
        queue_gestures(RANDOM_ITEMS);
        wait_idle();

        tx_idle_pct = 51;
        rx_idle_pct = 32;
        randomize_config(0, FULL_SCALE, 127, 0, 127, 127);
        queue_gestures(RANDOM_ITEMS);
        wait_idle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        randomize_config(400, 600, 15, 40, 60, 40);
        hold_pending = 1'b1;
        queue_gestures(RANDOM_ITEMS);
        wait_idle();

        if (predicted_reports.size() != 0) begin
            $display("%0t: %0d reports missing, expected %0d, actual 0", $time,
                     predicted_reports.size(), predicted_reports.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("PASS joystick_direction_hysteresis_top");
        end else begin
            $display("FAIL joystick_direction_hysteresis_top");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/jdh_pkg.sv
src/jdh_div.sv
src/jdh_heading.sv
src/joystick_direction_hysteresis_top.sv
verif/joystick_direction_hysteresis_top_test.sv
